// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
// jsu_pkg: shared types and constants of the json string unescaper
// used by jsu_ctrl, jsu_datapath, jsu_port_checker and json_string_unescaper_top

package jsu_pkg;

    // character codes
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_B         = 16'h0062;
    localparam logic [15:0] CH_F         = 16'h0066;
    localparam logic [15:0] CH_N         = 16'h006E;
    localparam logic [15:0] CH_R         = 16'h0072;
    localparam logic [15:0] CH_T         = 16'h0074;
    localparam logic [15:0] CH_U         = 16'h0075;

    // hex digit ranges
    localparam logic [15:0] CH_DIG_0     = 16'h0030;
    localparam logic [15:0] CH_DIG_9     = 16'h0039;
    localparam logic [15:0] CH_UC_A      = 16'h0041;
    localparam logic [15:0] CH_UC_F      = 16'h0046;
    localparam logic [15:0] CH_LC_A      = 16'h0061;
    localparam logic [15:0] CH_LC_F      = 16'h0066;

    // control codes produced by the short escapes
    localparam logic [15:0] CC_BS = 16'h0008;
    localparam logic [15:0] CC_FF = 16'h000C;
    localparam logic [15:0] CC_LF = 16'h000A;
    localparam logic [15:0] CC_CR = 16'h000D;
    localparam logic [15:0] CC_HT = 16'h0009;

    localparam int TAIL_DEPTH = 3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } jsu_in_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        out_valid;
        logic        out_last;
    } jsu_out_t;

    typedef enum logic [1:0] {
        ST_NORMAL,
        ST_ESCAPE,
        ST_HEX,
        ST_FLUSH
    } jsu_state_t;

    // source of the next value loaded into the output register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_RAW,
        EMIT_ESC,
        EMIT_HEX,
        EMIT_MARK,
        EMIT_TAIL
    } jsu_emit_t;

    typedef struct packed {
        jsu_emit_t emit;
        logic      out_last;
        logic      store_digit;
        logic      clear_count;
        logic      load_tail;
    } jsu_cmd_t;

    typedef struct packed {
        logic in_is_bs;
        logic in_is_u;
        logic in_last;
        logic hex_full;
        logic out_free;
        logic tail_last;
    } jsu_sts_t;

endpackage

// ===== design/jsu_ctrl.sv =====
`timescale 1ns / 1ps
// jsu_ctrl: decode state machine of the unescaper
// depends on jsu_pkg; drives commands into jsu_datapath

module jsu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  jsu_pkg::jsu_sts_t sts,
    output jsu_pkg::jsu_cmd_t cmd
);

    jsu_pkg::jsu_state_t state_reg;
    jsu_pkg::jsu_state_t state_next;
    logic                accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jsu_pkg::ST_NORMAL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_ready         = (state_reg != jsu_pkg::ST_FLUSH) && sts.out_free;
        accept          = s_valid && s_ready;
        state_next      = state_reg;
        cmd.emit        = jsu_pkg::EMIT_NONE;
        cmd.out_last    = sts.in_last;
        cmd.store_digit = 1'b0;
        cmd.clear_count = 1'b0;
        cmd.load_tail   = 1'b0;

        case (state_reg)
            jsu_pkg::ST_ESCAPE: begin
                if (accept) begin
                    state_next = jsu_pkg::ST_NORMAL;
                    if (sts.in_is_u) begin
                        cmd.clear_count = 1'b1;
                        if (sts.in_last) begin
                            cmd.emit = jsu_pkg::EMIT_MARK;
                        end else begin
                            state_next = jsu_pkg::ST_HEX;
                        end
                    end else begin
                        cmd.emit = jsu_pkg::EMIT_ESC;
                    end
                end
            end
            jsu_pkg::ST_HEX: begin
                if (accept) begin
                    if (sts.hex_full) begin
                        cmd.emit        = jsu_pkg::EMIT_HEX;
                        cmd.clear_count = 1'b1;
                        state_next      = jsu_pkg::ST_NORMAL;
                    end else if (sts.in_last) begin
                        cmd.load_tail   = 1'b1;
                        cmd.clear_count = 1'b1;
                        state_next      = jsu_pkg::ST_FLUSH;
                    end else begin
                        cmd.store_digit = 1'b1;
                    end
                end
            end
            jsu_pkg::ST_FLUSH: begin
                cmd.out_last = sts.tail_last;
                if (sts.out_free) begin
                    cmd.emit = jsu_pkg::EMIT_TAIL;
                    if (sts.tail_last) begin
                        state_next = jsu_pkg::ST_NORMAL;
                    end
                end
            end
            default: begin
                // normal mode
                if (accept) begin
                    if (sts.in_is_bs && !sts.in_last) begin
                        state_next = jsu_pkg::ST_ESCAPE;
                    end else begin
                        cmd.emit = jsu_pkg::EMIT_RAW;
                    end
                end
            end
        endcase
    end

endmodule

// ===== design/jsu_datapath.sv =====
`timescale 1ns / 1ps
// jsu_datapath: held digits, tail queue and output register of the unescaper
// depends on jsu_pkg; controlled by jsu_ctrl

module jsu_datapath #(
    parameter int UNIT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  jsu_pkg::jsu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jsu_pkg::jsu_out_t m_data,
    input  jsu_pkg::jsu_cmd_t cmd,
    output jsu_pkg::jsu_sts_t sts
);

    localparam logic [15:0] UNIT_MASK = 16'((32'd1 << UNIT_BITS) - 32'd1);

    function automatic logic [3:0] hex_value(input logic [15:0] c);
        logic [3:0] v;
        case (c) inside
            [16'h0030:16'h0039]: v = c[3:0];
            [16'h0041:16'h0046],
            [16'h0061:16'h0066]: v = 4'(c[3:0] + 4'd9);
            default:             v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] esc_map(input logic [15:0] c);
        logic [15:0] r;
        case (c)
            jsu_pkg::CH_B: r = jsu_pkg::CC_BS;
            jsu_pkg::CH_F: r = jsu_pkg::CC_FF;
            jsu_pkg::CH_N: r = jsu_pkg::CC_LF;
            jsu_pkg::CH_R: r = jsu_pkg::CC_CR;
            jsu_pkg::CH_T: r = jsu_pkg::CC_HT;
            default:       r = c;
        endcase
        return r;
    endfunction

    logic [15:0]       unit_in;
    logic [15:0]       held_reg [3];
    logic [1:0]        hex_count_reg;
    logic [1:0]        hex_count_next;
    jsu_pkg::jsu_out_t tail_reg [jsu_pkg::TAIL_DEPTH];
    jsu_pkg::jsu_out_t tail_next [jsu_pkg::TAIL_DEPTH];
    logic [1:0]        tail_idx_reg;
    logic [1:0]        tail_idx_next;
    jsu_pkg::jsu_out_t tail_head;
    jsu_pkg::jsu_out_t out_reg;
    jsu_pkg::jsu_out_t out_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [15:0]       hex_unit;

    // tail decode of held digits plus the final unit
    logic [15:0] b0, b1, b2;
    logic        slot_v [3];
    logic [15:0] slot_u [3];
    logic        a_two, b_done;
    logic [1:0]  k;
    logic [1:0]  last_k;
    logic        any_slot;

    assign unit_in  = s_data.code_unit & UNIT_MASK;
    assign hex_unit = {hex_value(held_reg[0]), hex_value(held_reg[1]),
                       hex_value(held_reg[2]), hex_value(unit_in)} & UNIT_MASK;

    always_comb begin
        case (tail_idx_reg)
            2'd1:    tail_head = tail_reg[1];
            2'd2:    tail_head = tail_reg[2];
            default: tail_head = tail_reg[0];
        endcase
    end

    assign sts.in_is_bs  = (unit_in == jsu_pkg::CH_BACKSLASH);
    assign sts.in_is_u   = (unit_in == jsu_pkg::CH_U);
    assign sts.in_last   = s_data.end_of_string;
    assign sts.hex_full  = (hex_count_reg == 2'd3);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.tail_last = tail_head.out_last;

    always_comb begin
        b0 = (hex_count_reg == 2'd0) ? unit_in : held_reg[0];
        b1 = (hex_count_reg == 2'd1) ? unit_in : held_reg[1];
        b2 = unit_in;

        // first position
        if (hex_count_reg != 2'd0 && b0 == jsu_pkg::CH_BACKSLASH) begin
            slot_v[0] = (b1 != jsu_pkg::CH_U);
            slot_u[0] = esc_map(b1);
            a_two     = 1'b1;
        end else begin
            slot_v[0] = 1'b1;
            slot_u[0] = b0;
            a_two     = 1'b0;
        end

        // second position, reached only after a plain first unit
        slot_v[1] = 1'b0;
        slot_u[1] = b1;
        b_done    = 1'b0;
        if (!a_two && hex_count_reg != 2'd0) begin
            if (hex_count_reg == 2'd2 && b1 == jsu_pkg::CH_BACKSLASH) begin
                slot_v[1] = (b2 != jsu_pkg::CH_U);
                slot_u[1] = esc_map(b2);
                b_done    = 1'b1;
            end else begin
                slot_v[1] = 1'b1;
            end
        end

        // third position, a lone trailing unit
        slot_v[2] = (hex_count_reg == 2'd2) && !b_done;
        slot_u[2] = b2;

        // pack the produced units into the queue
        for (int i = 0; i < jsu_pkg::TAIL_DEPTH; i++) begin
            tail_next[i] = '0;
        end
        k        = 2'd0;
        last_k   = 2'd0;
        any_slot = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (slot_v[i]) begin
                tail_next[k].out_unit  = slot_u[i];
                tail_next[k].out_valid = 1'b1;
                last_k                 = k;
                any_slot               = 1'b1;
                k                      = k + 2'd1;
            end
        end
        // bare end marker when nothing came out
        tail_next[last_k].out_last = 1'b1;
        if (!any_slot) begin
            tail_next[0] = '{out_unit: 16'd0, out_valid: 1'b0, out_last: 1'b1};
        end
    end

    always_comb begin
        hex_count_next = hex_count_reg;
        if (cmd.clear_count) begin
            hex_count_next = 2'd0;
        end else if (cmd.store_digit) begin
            hex_count_next = hex_count_reg + 2'd1;
        end

        tail_idx_next = tail_idx_reg;
        if (cmd.load_tail) begin
            tail_idx_next = 2'd0;
        end else if (cmd.emit == jsu_pkg::EMIT_TAIL) begin
            tail_idx_next = tail_idx_reg + 2'd1;
        end

        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (cmd.emit)
            jsu_pkg::EMIT_RAW: begin
                out_next     = '{out_unit: unit_in, out_valid: 1'b1, out_last: cmd.out_last};
                m_valid_next = 1'b1;
            end
            jsu_pkg::EMIT_ESC: begin
                out_next     = '{out_unit: esc_map(unit_in), out_valid: 1'b1,
                                 out_last: cmd.out_last};
                m_valid_next = 1'b1;
            end
            jsu_pkg::EMIT_HEX: begin
                out_next     = '{out_unit: hex_unit, out_valid: 1'b1, out_last: cmd.out_last};
                m_valid_next = 1'b1;
            end
            jsu_pkg::EMIT_MARK: begin
                out_next     = '{out_unit: 16'd0, out_valid: 1'b0, out_last: 1'b1};
                m_valid_next = 1'b1;
            end
            jsu_pkg::EMIT_TAIL: begin
                out_next     = tail_head;
                m_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_count_reg <= 2'd0;
            tail_idx_reg  <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            hex_count_reg <= hex_count_next;
            tail_idx_reg  <= tail_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.store_digit) begin
            held_reg[hex_count_reg] <= unit_in;
        end
        if (cmd.load_tail) begin
            for (int i = 0; i < jsu_pkg::TAIL_DEPTH; i++) begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/json_string_unescaper_top.sv =====
`timescale 1ns / 1ps
// json_string_unescaper_top: streaming json string body unescaper
// depends on jsu_pkg, jsu_ctrl and jsu_datapath

// The block decodes backslash escapes in the body of a JSON string, one
// 16-bit code unit per request, with end_of_string on the final unit. \b \f
// \n \r \t become control codes, \uXXXX becomes one unit (A-F and a-f are
// 10..15, any other digit reads as 0), and a backslash before anything else
// yields that character. Only the low UNIT_BITS bits of each unit take part.
// A request that completes nothing gives no result, except on the final unit,
// where an empty marker (out_valid low, out_last high) closes the string.
// Throughput is one request per cycle: results sit in a single output
// register, and a new request is taken whenever that register is empty or
// is being drained in the same cycle. When a string ends inside an unfinished
// \u sequence the held digits are decoded again as plain text into a small
// tail queue of up to three results; these leave the output register one per
// cycle while the sink accepts them, and the input stalls until the last is loaded.

module json_string_unescaper_top #(
    parameter int UNIT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jsu_pkg::jsu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jsu_pkg::jsu_out_t m_data
);

    // command and status between controller and datapath
    jsu_pkg::jsu_cmd_t cmd;
    jsu_pkg::jsu_sts_t sts;

    // state machine: normal, after backslash, collecting hex digits, tail drain
    jsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // held digits, digit count, tail queue and output register
    jsu_datapath #(
        .UNIT_BITS (UNIT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// ===== design/jsu_checker.sv =====
`timescale 1ns / 1ps
// jsu_port_checker: port-level checks of json_string_unescaper_top
// depends on jsu_pkg; bound to the top level below

module jsu_port_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input jsu_pkg::jsu_out_t m_data
);

    // a result waiting for the sink stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // an empty marker only ever closes a string
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_last)
        else $error("empty marker without end flag");

    // an empty marker carries a zero unit
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_unit == 16'd0)
        else $error("empty marker with nonzero unit");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind json_string_unescaper_top jsu_port_checker u_jsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/jsu_checker.sv =====
`timescale 1ns / 1ps
// jsu_checker: watches both channels of the json string unescaper, predicts
// the decoded units of every request and compares them in order
// depends on jsu_pkg

module jsu_checker #(
    parameter int UNIT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  jsu_pkg::jsu_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  jsu_pkg::jsu_out_t m_data,
    output int                mismatch_count,
    output int                outstanding,
    output int                results_checked
);

    localparam logic [15:0] UNIT_MASK = 16'((32'd1 << UNIT_BITS) - 32'd1);

    // predictor state
    jsu_pkg::jsu_state_t esc_state;
    logic [1:0]          digits_held;
    logic [15:0]         digit_store [jsu_pkg::TAIL_DEPTH];

    jsu_pkg::jsu_out_t expected_units[$];

    function automatic logic [3:0] hex_nibble(input logic [15:0] c);
        if (c >= jsu_pkg::CH_DIG_0 && c <= jsu_pkg::CH_DIG_9)
            return 4'(c - jsu_pkg::CH_DIG_0);
        if (c >= jsu_pkg::CH_UC_A && c <= jsu_pkg::CH_UC_F)
            return 4'(c - jsu_pkg::CH_UC_A + 16'd10);
        if (c >= jsu_pkg::CH_LC_A && c <= jsu_pkg::CH_LC_F)
            return 4'(c - jsu_pkg::CH_LC_A + 16'd10);
        return 4'd0;
    endfunction

    function automatic logic [15:0] short_escape(input logic [15:0] c);
        case (c)
            jsu_pkg::CH_B: return jsu_pkg::CC_BS;
            jsu_pkg::CH_F: return jsu_pkg::CC_FF;
            jsu_pkg::CH_N: return jsu_pkg::CC_LF;
            jsu_pkg::CH_R: return jsu_pkg::CC_CR;
            jsu_pkg::CH_T: return jsu_pkg::CC_HT;
            default:       return c;
        endcase
    endfunction

    function automatic jsu_pkg::jsu_out_t decoded(input logic [15:0] u);
        jsu_pkg::jsu_out_t r;
        r.out_unit  = u & UNIT_MASK;
        r.out_valid = 1'b1;
        r.out_last  = 1'b0;
        return r;
    endfunction

    function automatic void clear_decoder();
        esc_state   = jsu_pkg::ST_NORMAL;
        digits_held = 2'd0;
    endfunction

    // one accepted request: update the decoder and queue what it yields
    function automatic void unescape_step(input jsu_pkg::jsu_in_t req);
        logic [15:0]       c;
        logic              fin;
        logic [15:0]       tail[$];
        jsu_pkg::jsu_out_t res[$];
        jsu_pkg::jsu_out_t closing;
        int                i;
        c   = req.code_unit & UNIT_MASK;
        fin = req.end_of_string;
        case (esc_state)
            jsu_pkg::ST_ESCAPE: begin
                if (c == jsu_pkg::CH_U) begin
                    esc_state   = jsu_pkg::ST_HEX;
                    digits_held = 2'd0;
                end else begin
                    res.push_back(decoded(short_escape(c)));
                    esc_state = jsu_pkg::ST_NORMAL;
                end
            end
            jsu_pkg::ST_HEX: begin
                if (digits_held == 2'd3) begin
                    res.push_back(decoded({hex_nibble(digit_store[0]),
                                           hex_nibble(digit_store[1]),
                                           hex_nibble(digit_store[2]),
                                           hex_nibble(c)}));
                    esc_state   = jsu_pkg::ST_NORMAL;
                    digits_held = 2'd0;
                end else if (fin) begin
                    // string ended inside \u: drop the u, decode the rest as text
                    for (i = 0; i < int'(digits_held); i++) tail.push_back(digit_store[i]);
                    tail.push_back(c);
                    i = 0;
                    while (i < tail.size()) begin
                        if (tail[i] == jsu_pkg::CH_BACKSLASH && i + 1 < tail.size()) begin
                            // a \u here never has room for its four digits
                            if (tail[i + 1] != jsu_pkg::CH_U)
                                res.push_back(decoded(short_escape(tail[i + 1])));
                            i += 2;
                        end else begin
                            res.push_back(decoded(tail[i]));
                            i += 1;
                        end
                    end
                end else begin
                    digit_store[digits_held] = c;
                    digits_held = digits_held + 2'd1;
                end
            end
            default: begin
                if (c == jsu_pkg::CH_BACKSLASH && !fin) esc_state = jsu_pkg::ST_ESCAPE;
                else res.push_back(decoded(c));
            end
        endcase
        if (fin) begin
            if (res.size() == 0) begin
                closing.out_unit  = 16'h0000;
                closing.out_valid = 1'b0;
                closing.out_last  = 1'b1;
                res.push_back(closing);
            end else begin
                closing = res[res.size() - 1];
                closing.out_last = 1'b1;
                res[res.size() - 1] = closing;
            end
            clear_decoder();
        end
        foreach (res[k]) expected_units.push_back(res[k]);
    endfunction

    always @(posedge aclk) begin
        jsu_pkg::jsu_out_t want;
        if (!aresetn) begin
            clear_decoder();
            expected_units.delete();
        end else begin
            if (s_valid && s_ready) unescape_step(s_data);
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_units.size() == 0) begin
                    $error("unexpected result: unit %h valid %b last %b",
                           m_data.out_unit, m_data.out_valid, m_data.out_last);
                    mismatch_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (m_data.out_unit !== want.out_unit) begin
                        $error("out_unit: expected %h, got %h", want.out_unit, m_data.out_unit);
                        mismatch_count++;
                    end
                    if (m_data.out_valid !== want.out_valid) begin
                        $error("out_valid: expected %b, got %b", want.out_valid, m_data.out_valid);
                        mismatch_count++;
                    end
                    if (m_data.out_last !== want.out_last) begin
                        $error("out_last: expected %b, got %b", want.out_last, m_data.out_last);
                        mismatch_count++;
                    end
                end
            end
        end
        outstanding = expected_units.size();
    end

    final begin
        if (expected_units.size() != 0)
            $error("%0d results never arrived", expected_units.size());
    end

endmodule

// ===== dv/tb_json_string_unescaper_top.sv =====
`timescale 1ns / 1ps
// tb_json_string_unescaper_top: stimulus, flow control and verdict for the
// json string unescaper; depends on jsu_pkg, jsu_checker and the block itself

module tb_json_string_unescaper_top;

    localparam int UNIT_BITS      = 16;
    localparam int TARGET_UNITS   = 230;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    // characters used to build strings
    localparam logic [15:0] QUOTE = 16'h0022;
    localparam logic [15:0] SLASH = 16'h002F;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    jsu_pkg::jsu_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    jsu_pkg::jsu_out_t m_data;

    int mismatch_count;
    int outstanding;
    int results_checked;

    int units_sent   = 0;
    int strings_sent = 0;
    int ready_left   = 0;
    int quiet_cycles = 0;
    bit no_idling    = 1'b0;

    // units of the string about to be sent, end_of_string goes on the last
    logic [15:0] string_units[$];

    always #5 aclk = ~aclk;

    json_string_unescaper_top #(
        .UNIT_BITS(UNIT_BITS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    jsu_checker #(
        .UNIT_BITS(UNIT_BITS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .results_checked(results_checked)
    );

    // idle length: mostly none, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // hex digit in any of its spellings, or anything else (reads as zero)
    function automatic logic [15:0] any_hex_digit();
        case ($urandom_range(0, 3))
            0:       return jsu_pkg::CH_DIG_0 + 16'($urandom_range(0, 9));
            1:       return jsu_pkg::CH_UC_A + 16'($urandom_range(0, 5));
            2:       return jsu_pkg::CH_LC_A + 16'($urandom_range(0, 5));
            default: return 16'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    // the unit that follows a backslash
    function automatic logic [15:0] escape_letter();
        case ($urandom_range(0, 8))
            0:       return jsu_pkg::CH_B;
            1:       return jsu_pkg::CH_F;
            2:       return jsu_pkg::CH_N;
            3:       return jsu_pkg::CH_R;
            4:       return jsu_pkg::CH_T;
            5:       return jsu_pkg::CH_BACKSLASH;
            6:       return QUOTE;
            7:       return SLASH;
            default: return 16'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    // what can sit in the held digits when a string ends inside \u
    function automatic logic [15:0] tail_unit();
        case ($urandom_range(0, 4))
            0, 1:    return any_hex_digit();
            2:       return jsu_pkg::CH_BACKSLASH;
            3:       return escape_letter();
            default: return jsu_pkg::CH_U;
        endcase
    endfunction

    // mostly well-formed escapes with random content, plus noise and cut-off endings
    function automatic void compose_string();
        int n_tok;
        int n_held;
        string_units.delete();
        n_tok = $urandom_range(0, 6);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: string_units.push_back(16'($urandom_range(1, 16'hFFFF)));
                4, 5, 6: begin
                    string_units.push_back(jsu_pkg::CH_BACKSLASH);
                    string_units.push_back(escape_letter());
                end
                7, 8: begin
                    string_units.push_back(jsu_pkg::CH_BACKSLASH);
                    string_units.push_back(jsu_pkg::CH_U);
                    repeat (4) string_units.push_back(any_hex_digit());
                end
                default: string_units.push_back(tail_unit());
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: string_units.push_back(16'($urandom_range(1, 16'hFFFF)));
            4: begin
                // lone backslash on the final unit
                string_units.push_back(16'($urandom_range(1, 16'hFFFF)));
                string_units.push_back(jsu_pkg::CH_BACKSLASH);
            end
            5, 6, 7: begin
                // string runs out inside \u with zero to two digits held
                string_units.push_back(jsu_pkg::CH_BACKSLASH);
                string_units.push_back(jsu_pkg::CH_U);
                n_held = $urandom_range(0, 2);
                repeat (n_held + 1) string_units.push_back(tail_unit());
            end
            default: begin
                // end right on the last token
                if (string_units.size() == 0) string_units.push_back(jsu_pkg::CH_BACKSLASH);
                if (string_units.size() == 1 && string_units[0] == jsu_pkg::CH_BACKSLASH)
                    string_units.push_back(jsu_pkg::CH_U);
            end
        endcase
    endfunction

    // one request: optional gap, then hold valid until the block takes it.
    // entered and left at a falling edge
    task automatic send_unit(input logic [15:0] unit, input logic fin);
        int gap;
        gap = no_idling ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{code_unit: unit, end_of_string: fin};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        units_sent++;
    endtask

    task automatic send_string();
        foreach (string_units[i]) send_unit(string_units[i], i == string_units.size() - 1);
        strings_sent++;
    endtask

    // sink side: random stalls, always ready while no_idling is set
    always @(negedge aclk) begin
        if (no_idling) begin
            m_ready    <= 1'b1;
            ready_left <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 99) < 60) begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end else begin
            m_ready    <= 1'b0;
            ready_left <= idle_len();
        end
    end

    // watchdog: a stretch with no handshake on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;

        // synchronous reset, released at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short escapes and the largest unit as a plain character
        string_units = {jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_B, jsu_pkg::CH_BACKSLASH,
                        jsu_pkg::CH_T, 16'hFFFF};
        send_string();
        // fourth \u digit on the final unit, upper/lower hex and a non-hex digit
        string_units = {jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_U, jsu_pkg::CH_LC_A,
                        jsu_pkg::CH_UC_A + 16'd5, jsu_pkg::CH_DIG_0 + 16'd9,
                        jsu_pkg::CH_LC_A + 16'd25};
        send_string();
        // end inside \u with three units to replay
        string_units = {jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_U, jsu_pkg::CH_UC_A,
                        jsu_pkg::CH_UC_A + 16'd1, jsu_pkg::CH_UC_A + 16'd2};
        send_string();
        // smallest unit, then a backslash as the final unit
        string_units = {16'h0001, jsu_pkg::CH_BACKSLASH};
        send_string();
        // \u on the final unit: nothing decoded, bare end marker
        string_units = {jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_U};
        send_string();
        // escape among the replayed units
        string_units = {jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_U, jsu_pkg::CH_BACKSLASH,
                        jsu_pkg::CH_N, jsu_pkg::CH_LC_A + 16'd23};
        send_string();

        // random strings; three of every sixteen run without any idling
        while (units_sent < TARGET_UNITS) begin
            if (!paused && units_sent >= TARGET_UNITS / 2) begin
                // hold the sender until the block has drained completely
                s_valid <= 1'b0;
                @(negedge aclk);
                while (outstanding != 0) @(negedge aclk);
                paused = 1'b1;
            end
            no_idling = (strings_sent % 16) < 3;
            compose_string();
            send_string();
        end
        no_idling = 1'b0;
        s_valid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d requests in %0d strings with %0d results checked,",
                 units_sent, strings_sent, results_checked);
        $display("including short escapes, \\u runs, cut-off \\u endings and end markers");
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
